// ===== rtl/ffa_pkg.sv =====
package ffa_pkg;

    localparam int TAG_W          = 17;
    localparam int HEAP_WORDS_DEF = 4096;
    localparam int HEAP_BYTES_RST = 32768;
    localparam int CFG_ADDR_W     = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_HEAP_BYTES = 2'd0;

    localparam logic [1:0] ACT_ALLOC  = 2'd0;
    localparam logic [1:0] ACT_FREE   = 2'd1;
    localparam logic [1:0] ACT_FORMAT = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ZERO    = 2'd1;
    localparam logic [1:0] ST_NO_FIT  = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PUT_H,
        S_PUT_F,
        S_A_CHK,
        S_A_EVAL,
        S_A_SPLIT,
        S_F_HDR,
        S_F_FTR,
        S_F_PRV,
        S_F_PEV,
        S_F_NXT,
        S_F_NEV,
        S_FMT,
        S_DONE
    } state_t;

endpackage

// ===== rtl/ffa_ram.sv =====
module ffa_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== rtl/first_fit_heap_allocator.sv =====
// First-fit heap allocator over a tag memory of HEAP_WORDS words, one word per 8 bytes.
// Each item (allocate, free or format) gives one result item. Allocate reads and
// checks each block header visited in the first-fit walk, then writes the header and
// footer of the granted block and, on a split, of the free remainder, so its time
// grows with fragmentation. Format, and the power-up after reset, clear the whole
// tag memory one word a cycle and then write the first free block; no item is
// accepted meanwhile.
// The power-up clear gives no result item.
// The single-port tag memory is the limit throughout: one read or one write a cycle.
// heap_bytes takes effect at the next format.
module first_fit_heap_allocator #(
    parameter int HEAP_WORDS = ffa_pkg::HEAP_WORDS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,  // request_bytes[15:0], block_offset[30:16]
    input  logic [1:0]                    s_tuser,  // action[1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,  // status[1:0], user_offset[16:2]
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ffa_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int AW = $clog2(HEAP_WORDS);
    localparam int BW = (AW + 4 > 18) ? AW + 4 : 18;
    localparam int TW = ffa_pkg::TAG_W;

    localparam logic [BW-1:0] CAP    = BW'(HEAP_WORDS) << 3;
    localparam logic [BW-1:0] B8     = BW'(8);
    localparam logic [BW-1:0] B16    = BW'(16);
    localparam logic [BW-1:0] RST_SZ =
        ((BW'(ffa_pkg::HEAP_BYTES_RST) < CAP) ? BW'(ffa_pkg::HEAP_BYTES_RST) : CAP)
        & ~BW'(15);

    ffa_pkg::state_t state_reg, state_next, ret_reg, ret_next;

    logic [15:0]   heap_bytes_reg;
    logic [BW-1:0] heap_end_reg, heap_end_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [BW-1:0] pos_reg, pos_next;
    logic [BW-1:0] need_reg, need_next;
    logic [BW-1:0] size_reg, size_next;
    logic [TW-1:0] tag_reg, tag_next;
    logic [BW-1:0] put_start_reg, put_start_next;
    logic [BW-1:0] put_size_reg, put_size_next;
    logic          put_used_reg, put_used_next;
    logic          oob_reg, oob_next;
    logic [1:0]    res_st_reg, res_st_next;
    logic [14:0]   res_off_reg, res_off_next;
    logic          m_valid_reg, m_valid_next;
    logic [1:0]    m_st_reg, m_st_next;
    logic [14:0]   m_off_reg, m_off_next;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [TW-1:0] ram_wdata, ram_rdata, rd_tag;
    logic [BW-1:0] rd_size, b_tmp, hdr, fmt_sz;
    logic [15:0]   req;
    logic [14:0]   boff;

    ffa_ram #(.WIDTH(TW), .DEPTH(HEAP_WORDS)) u_tags (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign req      = s_tdata[15:0];
    assign boff     = s_tdata[30:16];
    assign s_tready = (state_reg == ffa_pkg::S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_off_reg, m_st_reg};
    assign pready   = 1'b1;
    assign prdata   = {16'd0, heap_bytes_reg};
    assign rd_tag   = oob_reg ? '0 : ram_rdata;
    assign rd_size  = BW'(rd_tag[TW-1:1]);
    assign hdr      = BW'(boff) - B8;

    always_comb
    begin
        fmt_sz = (BW'(heap_bytes_reg) < CAP) ? BW'(heap_bytes_reg) : CAP;
        fmt_sz = fmt_sz & ~BW'(15);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_bytes_reg <= 16'(ffa_pkg::HEAP_BYTES_RST);
        end
        else if (psel && penable && pwrite && paddr == ffa_pkg::REG_HEAP_BYTES)
        begin
            heap_bytes_reg <= pwdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ffa_pkg::S_CLEAR;
            ret_reg      <= ffa_pkg::S_IDLE;
            heap_end_reg <= RST_SZ;
            clr_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ret_reg      <= ret_next;
            heap_end_reg <= heap_end_next;
            clr_reg      <= clr_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        need_reg      <= need_next;
        size_reg      <= size_next;
        tag_reg       <= tag_next;
        put_start_reg <= put_start_next;
        put_size_reg  <= put_size_next;
        put_used_reg  <= put_used_next;
        oob_reg       <= oob_next;
        res_st_reg    <= res_st_next;
        res_off_reg   <= res_off_next;
        m_st_reg      <= m_st_next;
        m_off_reg     <= m_off_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        heap_end_next  = heap_end_reg;
        clr_next       = clr_reg;
        pos_next       = pos_reg;
        need_next      = need_reg;
        size_next      = size_reg;
        tag_next       = tag_reg;
        put_start_next = put_start_reg;
        put_size_next  = put_size_reg;
        put_used_next  = put_used_reg;
        oob_next       = 1'b0;
        res_st_next    = res_st_reg;
        res_off_next   = res_off_reg;
        m_valid_next   = m_valid_reg;
        m_st_next      = m_st_reg;
        m_off_next     = m_off_reg;
        ram_we         = 1'b0;
        ram_addr       = '0;
        ram_wdata      = '0;
        b_tmp          = '0;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ffa_pkg::S_CLEAR:
            begin
                ram_we   = 1'b1;
                ram_addr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(HEAP_WORDS - 1))
                begin
                    clr_next  = '0;
                    state_next = ffa_pkg::S_FMT;
                end
            end
            ffa_pkg::S_FMT:
            begin
                // ret_reg is S_DONE for a format item and S_IDLE for the
                // clear after reset, which gives no result item.
                res_st_next  = ffa_pkg::ST_OK;
                res_off_next = '0;
                if (heap_end_reg >= B16)
                begin
                    put_start_next = '0;
                    put_size_next  = heap_end_reg;
                    put_used_next  = 1'b0;
                    state_next     = ffa_pkg::S_PUT_H;
                end
                else
                begin
                    state_next = ret_reg;
                end
            end
            ffa_pkg::S_IDLE:
            begin
                res_st_next  = ffa_pkg::ST_OK;
                res_off_next = '0;
                if (s_tvalid)
                begin
                    state_next = ffa_pkg::S_DONE;
                    unique case (s_tuser)
                        ffa_pkg::ACT_ALLOC:
                        begin
                            if (req == 16'd0)
                            begin
                                res_st_next = ffa_pkg::ST_ZERO;
                            end
                            else
                            begin
                                need_next  = ((BW'(req) + BW'(7)) & ~BW'(7)) + B16;
                                pos_next   = '0;
                                state_next = ffa_pkg::S_A_CHK;
                            end
                        end
                        ffa_pkg::ACT_FREE:
                        begin
                            if (boff >= 15'd8 && boff[2:0] == 3'd0)
                            begin
                                ram_addr   = hdr[AW+2:3];
                                oob_next   = (hdr >> 3) >= BW'(HEAP_WORDS);
                                pos_next   = hdr;
                                state_next = ffa_pkg::S_F_HDR;
                            end
                        end
                        ffa_pkg::ACT_FORMAT:
                        begin
                            heap_end_next = fmt_sz;
                            clr_next      = '0;
                            ret_next      = ffa_pkg::S_DONE;
                            state_next    = ffa_pkg::S_CLEAR;
                        end
                        default:
                        begin
                            state_next = ffa_pkg::S_DONE;
                        end
                    endcase
                end
            end
            ffa_pkg::S_PUT_H:
            begin
                ram_we     = 1'b1;
                ram_addr   = put_start_reg[AW+2:3];
                ram_wdata  = {put_size_reg[TW-2:0], put_used_reg};
                state_next = ffa_pkg::S_PUT_F;
            end
            ffa_pkg::S_PUT_F:
            begin
                b_tmp      = put_start_reg + put_size_reg - B8;
                ram_we     = 1'b1;
                ram_addr   = b_tmp[AW+2:3];
                ram_wdata  = {put_size_reg[TW-2:0], put_used_reg};
                state_next = ret_reg;
            end
            ffa_pkg::S_A_CHK:
            begin
                if (pos_reg + need_reg <= heap_end_reg)
                begin
                    ram_addr   = pos_reg[AW+2:3];
                    state_next = ffa_pkg::S_A_EVAL;
                end
                else
                begin
                    res_st_next = ffa_pkg::ST_NO_FIT;
                    state_next  = ffa_pkg::S_DONE;
                end
            end
            ffa_pkg::S_A_EVAL:
            begin
                if (rd_size < B16 || rd_size[2:0] != 3'd0
                    || pos_reg + rd_size > heap_end_reg)
                begin
                    res_st_next = ffa_pkg::ST_NO_FIT;
                    state_next  = ffa_pkg::S_DONE;
                end
                else if (!rd_tag[0] && rd_size >= need_reg)
                begin
                    res_off_next   = 15'(pos_reg + B8);
                    put_start_next = pos_reg;
                    put_used_next  = 1'b1;
                    size_next      = rd_size - need_reg;
                    state_next     = ffa_pkg::S_PUT_H;
                    if (rd_size - need_reg < B16)
                    begin
                        put_size_next = rd_size;
                        ret_next      = ffa_pkg::S_DONE;
                    end
                    else
                    begin
                        put_size_next = need_reg;
                        ret_next      = ffa_pkg::S_A_SPLIT;
                    end
                end
                else
                begin
                    pos_next   = pos_reg + rd_size;
                    state_next = ffa_pkg::S_A_CHK;
                end
            end
            ffa_pkg::S_A_SPLIT:
            begin
                // The remainder becomes a free block right after the granted one.
                put_start_next = pos_reg + need_reg;
                put_size_next  = size_reg;
                put_used_next  = 1'b0;
                ret_next       = ffa_pkg::S_DONE;
                state_next     = ffa_pkg::S_PUT_H;
            end
            ffa_pkg::S_F_HDR:
            begin
                tag_next  = rd_tag;
                size_next = rd_size;
                b_tmp     = pos_reg + rd_size - B8;
                if (rd_tag[0] && rd_size >= B16 && rd_size[2:0] == 3'd0
                    && pos_reg + rd_size <= heap_end_reg)
                begin
                    ram_addr   = b_tmp[AW+2:3];
                    state_next = ffa_pkg::S_F_FTR;
                end
                else
                begin
                    state_next = ffa_pkg::S_DONE;
                end
            end
            ffa_pkg::S_F_FTR:
            begin
                if (rd_tag == tag_reg)
                begin
                    put_start_next = pos_reg;
                    put_size_next  = size_reg;
                    put_used_next  = 1'b0;
                    ret_next       = ffa_pkg::S_F_PRV;
                    state_next     = ffa_pkg::S_PUT_H;
                end
                else
                begin
                    state_next = ffa_pkg::S_DONE;
                end
            end
            ffa_pkg::S_F_PRV:
            begin
                if (pos_reg != '0)
                begin
                    b_tmp      = pos_reg - B8;
                    ram_addr   = b_tmp[AW+2:3];
                    state_next = ffa_pkg::S_F_PEV;
                end
                else
                begin
                    state_next = ffa_pkg::S_F_NXT;
                end
            end
            ffa_pkg::S_F_PEV:
            begin
                state_next = ffa_pkg::S_F_NXT;
                if (!rd_tag[0] && rd_size >= B16 && rd_size <= pos_reg)
                begin
                    pos_next       = pos_reg - rd_size;
                    size_next      = size_reg + rd_size;
                    put_start_next = pos_reg - rd_size;
                    put_size_next  = size_reg + rd_size;
                    put_used_next  = 1'b0;
                    ret_next       = ffa_pkg::S_F_NXT;
                    state_next     = ffa_pkg::S_PUT_H;
                end
            end
            ffa_pkg::S_F_NXT:
            begin
                b_tmp = pos_reg + size_reg;
                if (b_tmp < heap_end_reg)
                begin
                    ram_addr   = b_tmp[AW+2:3];
                    state_next = ffa_pkg::S_F_NEV;
                end
                else
                begin
                    state_next = ffa_pkg::S_DONE;
                end
            end
            ffa_pkg::S_F_NEV:
            begin
                state_next = ffa_pkg::S_DONE;
                if (!rd_tag[0] && rd_size >= B16
                    && pos_reg + size_reg + rd_size <= heap_end_reg)
                begin
                    put_start_next = pos_reg;
                    put_size_next  = size_reg + rd_size;
                    put_used_next  = 1'b0;
                    ret_next       = ffa_pkg::S_DONE;
                    state_next     = ffa_pkg::S_PUT_H;
                end
            end
            ffa_pkg::S_DONE:
            begin
                // Wait for the output register to drain before loading the result.
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_st_next    = res_st_reg;
                    m_off_next   = res_off_reg;
                    state_next   = ffa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ffa_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== tb/sv/first_fit_heap_allocator_tb.sv =====
module first_fit_heap_allocator_tb;

    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int TAG_WORDS = 4096;
    localparam int STALL_LIMIT = 30000;
    localparam int SEG_ITEMS = 50;

    typedef struct {
        logic [1:0]  action;
        logic [15:0] req;
        logic [14:0] boff;
        bit          typed;
        logic [1:0]  status;
        logic [14:0] uoff;
    } dir_row_t;

    typedef struct {
        logic [1:0]  status;
        logic [14:0] uoff;
    } grant_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ffa_pkg::CFG_ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    first_fit_heap_allocator u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Shadow of the tag memory and heap registers.
    logic [16:0] tags [TAG_WORDS];
    int unsigned heap_bytes_reg;
    int unsigned heap_limit;

    grant_t      grants_due[$];
    int unsigned live_offsets[$];
    int          n_accepted;
    int          n_errors;
    int          quiet_cycles;
    int          send_idle_pct;
    int          recv_stall_pct;

    // Typed expectation for the item currently on the bus, if any.
    bit          cur_typed;
    logic [1:0]  cur_status;
    logic [14:0] cur_uoff;

    function automatic logic [16:0] tag_at(input int unsigned off);
        return (off / 8 < TAG_WORDS) ? tags[off / 8] : 17'd0;
    endfunction

    function automatic void tag_put(input int unsigned off, input int unsigned v);
        if (off / 8 < TAG_WORDS)
            tags[off / 8] = v[16:0];
    endfunction

    function automatic void mark_block(input int unsigned start, input int unsigned size,
                                       input bit used);
        tag_put(start, (size << 1) | 32'(used));
        tag_put(start + size - 8, (size << 1) | 32'(used));
    endfunction

    function automatic void heap_format();
        int unsigned sz;
        sz = (heap_bytes_reg < TAG_WORDS * 8) ? heap_bytes_reg : TAG_WORDS * 8;
        sz = sz & ~32'd15;
        for (int i = 0; i < TAG_WORDS; i++)
            tags[i] = '0;
        heap_limit = sz;
        if (sz >= 16)
            mark_block(0, sz, 1'b0);
    endfunction

    function automatic bit size_ok(input int unsigned start, input int unsigned size);
        return size >= 16 && size % 8 == 0 && start + size <= heap_limit;
    endfunction

    function automatic void heap_alloc(input int unsigned req, output logic [1:0] st,
                                       output logic [14:0] uo);
        int unsigned need;
        int unsigned pos;
        int unsigned t;
        int unsigned size;
        st = ffa_pkg::ST_NO_FIT;
        uo = '0;
        if (req == 0)
        begin
            st = ffa_pkg::ST_ZERO;
            return;
        end
        need = ((req + 7) & ~32'd7) + 16;
        pos = 0;
        while (pos + need <= heap_limit)
        begin
            t = 32'(tag_at(pos));
            size = t >> 1;
            if (!size_ok(pos, size))
                return;
            if (t[0] == 1'b0 && size >= need)
            begin
                if (size - need < 16)
                    mark_block(pos, size, 1'b1);
                else
                begin
                    mark_block(pos, need, 1'b1);
                    mark_block(pos + need, size - need, 1'b0);
                end
                st = ffa_pkg::ST_OK;
                uo = 15'(pos + 8);
                return;
            end
            pos += size;
        end
    endfunction

    function automatic void heap_release(input int unsigned p);
        int unsigned t;
        int unsigned size;
        int unsigned start;
        int unsigned nt;
        if (p < 8 || p % 8 != 0)
            return;
        start = p - 8;
        t = 32'(tag_at(start));
        size = t >> 1;
        if (t[0] == 1'b0 || !size_ok(start, size))
            return;
        if (32'(tag_at(start + size - 8)) != t)
            return;
        mark_block(start, size, 1'b0);
        if (start != 0)
        begin
            nt = 32'(tag_at(start - 8));
            if (nt[0] == 1'b0 && (nt >> 1) >= 16 && (nt >> 1) <= start)
            begin
                start -= nt >> 1;
                size += nt >> 1;
                mark_block(start, size, 1'b0);
            end
        end
        if (start + size < heap_limit)
        begin
            nt = 32'(tag_at(start + size));
            if (nt[0] == 1'b0 && (nt >> 1) >= 16 && start + size + (nt >> 1) <= heap_limit)
            begin
                size += nt >> 1;
                mark_block(start, size, 1'b0);
            end
        end
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("error: %s got %0d expected %0d", what, got, want);
        n_errors++;
    endtask

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Acceptance, prediction, result checking and the watchdog, all on the rising edge.
    always @(posedge clk)
    begin
        grant_t g;
        grant_t want;
        if (rst_n && s_tvalid && s_tready)
        begin
            g.status = ffa_pkg::ST_OK;
            g.uoff = '0;
            case (s_tuser)
                ffa_pkg::ACT_ALLOC:  heap_alloc(32'(s_tdata[15:0]), g.status, g.uoff);
                ffa_pkg::ACT_FREE:   heap_release(32'(s_tdata[30:16]));
                ffa_pkg::ACT_FORMAT:
                begin
                    heap_format();
                    live_offsets.delete();
                end
                default: ;
            endcase
            if (s_tuser == ffa_pkg::ACT_ALLOC && g.status == ffa_pkg::ST_OK)
                live_offsets.push_back(32'(g.uoff));
            if (cur_typed)
            begin
                g.status = cur_status;
                g.uoff = cur_uoff;
            end
            grants_due.push_back(g);
            n_accepted++;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (grants_due.size() == 0)
                report("unexpected result, status", m_tdata[1:0], -1);
            else
            begin
                want = grants_due.pop_front();
                if (m_tdata[1:0] !== want.status)
                    report("status", m_tdata[1:0], want.status);
                if (m_tdata[16:2] !== want.uoff)
                    report("user_offset", m_tdata[16:2], want.uoff);
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("first_fit_heap_allocator: mismatch");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(input logic [1:0] action, input logic [15:0] req,
                             input logic [14:0] boff, input bit typed,
                             input logic [1:0] st, input logic [14:0] uo);
        int seen;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        seen = n_accepted;
        s_tvalid <= 1'b1;
        s_tuser <= action;
        s_tdata <= {1'b0, boff, req};
        cur_typed <= typed;
        cur_status <= st;
        cur_uoff <= uo;
        do
            @(negedge clk);
        while (n_accepted == seen);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (grants_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_heap_bytes(input int unsigned v);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ffa_pkg::REG_HEAP_BYTES;
        pwdata <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        heap_bytes_reg = v & 32'hFFFF;
    endtask

    task automatic random_item();
        int unsigned r;
        int unsigned k;
        r = $urandom_range(99);
        if (r < 45)
            send_item(ffa_pkg::ACT_ALLOC,
                      16'(($urandom_range(9) == 0) ? $urandom_range(1, 4096)
                                                   : $urandom_range(1, 200)),
                      15'($urandom), 1'b0, '0, '0);
        else if (r < 80 && live_offsets.size() != 0)
        begin
            k = $urandom_range(live_offsets.size() - 1);
            send_item(ffa_pkg::ACT_FREE, 16'($urandom), 15'(live_offsets[k]), 1'b0, '0, '0);
            live_offsets.delete(k);
        end
        else if (r < 88)
            send_item(ffa_pkg::ACT_FREE, 16'($urandom), 15'($urandom), 1'b0, '0, '0);
        else if (r < 94)
            send_item(ffa_pkg::ACT_ALLOC, 16'($urandom), 15'($urandom), 1'b0, '0, '0);
        else if (r < 96)
            send_item(ffa_pkg::ACT_FORMAT, 16'($urandom), 15'($urandom), 1'b0, '0, '0);
        else
            send_item(ACT_NONE, 16'($urandom), 15'($urandom), 1'b0, '0, '0);
    endtask

    dir_row_t dir_rows[$];

    initial
    begin
        int unsigned cfg;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cur_typed = 1'b0;
        cur_status = '0;
        cur_uoff = '0;
        n_accepted = 0;
        n_errors = 0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        heap_bytes_reg = ffa_pkg::HEAP_BYTES_RST;
        heap_format();

        // After reset the heap is one free block of 32768 bytes.
        dir_rows = '{
            '{ffa_pkg::ACT_ALLOC,  16'd0,     15'd0,    1'b1, ffa_pkg::ST_ZERO,   15'd0},
            '{ffa_pkg::ACT_ALLOC,  16'hFFFF,  15'h7FFF, 1'b1, ffa_pkg::ST_NO_FIT, 15'd0},
            '{ffa_pkg::ACT_ALLOC,  16'd32768, 15'd0,    1'b1, ffa_pkg::ST_NO_FIT, 15'd0},
            '{ffa_pkg::ACT_ALLOC,  16'd32752, 15'd0,    1'b1, ffa_pkg::ST_OK,     15'd8},
            '{ffa_pkg::ACT_ALLOC,  16'd1,     15'd0,    1'b1, ffa_pkg::ST_NO_FIT, 15'd0},
            '{ffa_pkg::ACT_FREE,   16'd0,     15'd8,    1'b1, ffa_pkg::ST_OK,     15'd0},
            '{ffa_pkg::ACT_FREE,   16'd0,     15'd8,    1'b0, ffa_pkg::ST_OK,     15'd0},
            '{ffa_pkg::ACT_ALLOC,  16'd1,     15'd0,    1'b1, ffa_pkg::ST_OK,     15'd8},
            '{ffa_pkg::ACT_ALLOC,  16'd9,     15'd0,    1'b0, ffa_pkg::ST_OK,     15'd0},
            '{ffa_pkg::ACT_ALLOC,  16'd100,   15'd0,    1'b0, ffa_pkg::ST_OK,     15'd0},
            '{ffa_pkg::ACT_ALLOC,  16'd7,     15'd0,    1'b0, ffa_pkg::ST_OK,     15'd0},
            '{ffa_pkg::ACT_FREE,   16'd0,     15'd7,    1'b1, ffa_pkg::ST_OK,     15'd0},
            '{ffa_pkg::ACT_FREE,   16'd0,     15'd0,    1'b1, ffa_pkg::ST_OK,     15'd0},
            '{ffa_pkg::ACT_FREE,   16'd0,     15'd32,   1'b0, ffa_pkg::ST_OK,     15'd0},
            '{ffa_pkg::ACT_FREE,   16'd0,     15'd8,    1'b0, ffa_pkg::ST_OK,     15'd0},
            '{ffa_pkg::ACT_FREE,   16'd0,     15'd40,   1'b0, ffa_pkg::ST_OK,     15'd0},
            '{ffa_pkg::ACT_ALLOC,  16'd40,    15'd0,    1'b0, ffa_pkg::ST_OK,     15'd0},
            '{ffa_pkg::ACT_FREE,   16'd0,     15'h7FF8, 1'b0, ffa_pkg::ST_OK,     15'd0},
            '{ACT_NONE,            16'hFFFF,  15'h7FFF, 1'b1, ffa_pkg::ST_OK,     15'd0},
            '{ffa_pkg::ACT_FORMAT, 16'd0,     15'd0,    1'b1, ffa_pkg::ST_OK,     15'd0},
            '{ffa_pkg::ACT_ALLOC,  16'd32744, 15'd0,    1'b1, ffa_pkg::ST_OK,     15'd8},
            '{ffa_pkg::ACT_FREE,   16'd0,     15'd8,    1'b1, ffa_pkg::ST_OK,     15'd0}
        };

        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        recv_stall_pct = 20;
        foreach (dir_rows[i])
            send_item(dir_rows[i].action, dir_rows[i].req, dir_rows[i].boff,
                      dir_rows[i].typed, dir_rows[i].status, dir_rows[i].uoff);
        drain();

        // Tiny heaps: a 48 byte heap holds exactly two of the smallest blocks.
        write_heap_bytes(48);
        send_item(ffa_pkg::ACT_FORMAT, '0, '0, 1'b0, '0, '0);
        send_item(ffa_pkg::ACT_ALLOC, 16'd8, '0, 1'b0, '0, '0);
        send_item(ffa_pkg::ACT_ALLOC, 16'd1, '0, 1'b0, '0, '0);
        drain();
        write_heap_bytes(32);
        send_item(ffa_pkg::ACT_FORMAT, '0, '0, 1'b0, '0, '0);
        send_item(ffa_pkg::ACT_ALLOC, 16'd16, '0, 1'b1, ffa_pkg::ST_OK, 15'd8);
        send_item(ffa_pkg::ACT_ALLOC, 16'd8, '0, 1'b1, ffa_pkg::ST_NO_FIT, '0);
        send_item(ffa_pkg::ACT_FREE, '0, 15'd8, 1'b1, ffa_pkg::ST_OK, '0);
        drain();

        for (int seg = 0; seg < 12; seg++)
        begin
            send_idle_pct = (seg < 4) ? 31 : (seg < 8) ? 64 : 0;
            recv_stall_pct = (seg < 4) ? 64 : (seg < 8) ? 31 : 0;
            case (seg % 4)
                0: cfg = 32768;
                1: cfg = $urandom_range(32, 47);
                2: cfg = $urandom_range(32, 32768);
                default: cfg = $urandom_range(64, 2048);
            endcase
            write_heap_bytes(cfg);
            send_item(ffa_pkg::ACT_FORMAT, 16'($urandom), 15'($urandom), 1'b0, '0, '0);
            for (int n = 0; n < SEG_ITEMS; n++)
                random_item();
            drain();
        end

        repeat (50) @(negedge clk);
        if (n_errors == 0 && grants_due.size() == 0)
            $display("first_fit_heap_allocator: match");
        else
            $display("first_fit_heap_allocator: mismatch");
        $finish;
    end

endmodule
